// ===== hdl/rational_arithmetic_unit_macros.svh =====
// Assertion helpers for the checker file of this block.
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// A clocked property that is switched off while reset is asserted.
`define RAU_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// A property that is checked during reset as well.
`define RAU_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/rau_pkg.sv =====
package rau_pkg;

    // Operation codes carried with each request.
    typedef enum logic [3:0] {
        OP_ADD       = 4'd0,
        OP_SUB       = 4'd1,
        OP_MUL       = 4'd2,
        OP_DIV       = 4'd3,
        OP_EQ        = 4'd4,
        OP_NE        = 4'd5,
        OP_GT        = 4'd6,
        OP_LT        = 4'd7,
        OP_GE        = 4'd8,
        OP_LE        = 4'd9,
        OP_REDUCE    = 4'd10,
        OP_PROPER    = 4'd11
    } opcode_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FINISH
    } state_t;

    // Products formed one after another on the serial multiplier.
    typedef enum logic [2:0] {
        MS_LEFT_N,
        MS_RIGHT_N,
        MS_LEFT_X,
        MS_RIGHT_X,
        MS_DEN,
        MS_PROD
    } mul_step_t;

    // Uses of the serial divider.
    typedef enum logic [1:0] {
        DP_GCD,
        DP_NUM,
        DP_DEN,
        DP_PROPER
    } div_phase_t;

    // Status of a multi-cycle arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

endpackage

// ===== hdl/rau_mul.sv =====
module rau_mul #(
    parameter int AW = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [AW-1:0]     a,
    input  logic signed [AW-1:0]     b,
    output rau_pkg::unit_status_t    status,
    output logic signed [2*AW-1:0]   product
);

    localparam int CW = $clog2(AW);

    logic [2*AW-1:0] acc_reg;
    logic [2*AW-1:0] mcand_reg;
    logic [AW-1:0]   mplier_reg;
    logic            neg_reg;
    logic [CW-1:0]   cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [AW-1:0]   a_mag;
    logic [AW-1:0]   b_mag;

    // Operand magnitudes; the most negative value maps to its unsigned magnitude.
    assign a_mag = a[AW-1] ? AW'(-a) : AW'(a);
    assign b_mag = b[AW-1] ? AW'(-b) : AW'(b);

    // Control: one multiplier bit is retired per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(AW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift-and-add datapath.
    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            acc_reg    <= '0;
            mcand_reg  <= (2*AW)'(a_mag);
            mplier_reg <= b_mag;
            neg_reg    <= a[AW-1] ^ b[AW-1];
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[2*AW-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[AW-1:1]};
        end
    end

    assign product     = neg_reg ? $signed(-acc_reg) : $signed(acc_reg);
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== hdl/rau_div.sv =====
module rau_div #(
    parameter int NB = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [NB-1:0]         dividend,
    input  logic [NB-1:0]         divisor,
    output rau_pkg::unit_status_t status,
    output logic [NB-1:0]         quotient,
    output logic [NB-1:0]         remainder
);

    localparam int CW = $clog2(NB);

    logic [NB-1:0] rem_reg;
    logic [NB-1:0] quo_reg;
    logic [NB-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [NB:0]   shifted;
    logic [NB:0]   diff;

    // One restoring step: bring down the next dividend bit and try a subtract.
    assign shifted = {rem_reg, quo_reg[NB-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(NB - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= diff[NB] ? shifted[NB-1:0] : diff[NB-1:0];
            quo_reg <= {quo_reg[NB-2:0], ~diff[NB]};
        end
    end

    assign quotient    = quo_reg;
    assign remainder   = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== hdl/rational_arithmetic_unit.sv =====
// Rational arithmetic on two mixed fractions.
// Input channel s_*: one request carries an opcode in s_tuser and both mixed
// fractions in s_tdata. Output channel m_*: one result per request.
// The sequencer works on one request at a time. Products come from a
// bit-serial multiplier that retires one bit per cycle; quotients come from
// a bit-serial restoring divider.
// Compares use four products; add, sub and div five; mul six. The
// proper-form split uses one division; reduce uses one division per Euclid
// step and then two more. Unused opcodes and reduce of a zero numerator go
// straight to the finish state.
// A new request is taken only once the sequencer has finished the last one;
// s_tready is high only while the sequencer is idle.
// A finished result sits in the output register until it is taken, and a new
// request is accepted meanwhile. When the receiver stalls, the next result
// waits in the sequencer until the output register is free.
// Reset (aresetn low, synchronous) returns the sequencer to idle and drops
// m_tvalid.
module rational_arithmetic_unit #(
    parameter int OPERAND_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // left_integer, left_numerator, left_denominator,
    // right_integer, right_numerator, right_denominator
    input  logic [(((6 * OPERAND_BITS - 2) + 7) / 8) * 8 - 1:0] s_tdata,
    // opcode
    input  logic [3:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // result_integer, result_numerator, result_denominator, compare_true
    output logic [((7 * OPERAND_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int W      = OPERAND_BITS;
    localparam int DW     = W - 1;
    localparam int IW     = W + 1;
    localparam int NW     = 3 * W - 1;
    localparam int AW     = 2 * W;
    localparam int PW     = 4 * W;
    localparam int M_BITS = 7 * W;
    localparam int M_PAD  = ((M_BITS + 7) / 8) * 8;

    // Request fields.
    logic signed [W-1:0] in_li, in_ln, in_ri, in_rn;
    logic [DW-1:0]       in_ld_raw, in_rd_raw;
    logic [W-1:0]        in_ln_mag;
    rau_pkg::opcode_t    in_op;

    assign in_li     = s_tdata[W-1:0];
    assign in_ln     = s_tdata[2*W-1:W];
    assign in_ld_raw = s_tdata[3*W-2:2*W];
    assign in_ri     = s_tdata[4*W-2:3*W-1];
    assign in_rn     = s_tdata[5*W-2:4*W-1];
    assign in_rd_raw = s_tdata[6*W-3:5*W-1];
    assign in_op     = rau_pkg::opcode_t'(s_tuser);
    assign in_ln_mag = in_ln[W-1] ? W'(-in_ln) : W'(in_ln);

    rau_pkg::state_t     state_reg, state_next;
    rau_pkg::mul_step_t  mul_step_reg;
    rau_pkg::div_phase_t div_phase_reg;
    rau_pkg::opcode_t    op_reg;

    logic signed [W-1:0]  li_reg, ln_reg, ri_reg, rn_reg;
    logic [DW-1:0]        ld_reg, rd_reg;
    logic signed [AW-1:0] left_num_reg, right_num_reg;
    logic signed [NW-1:0] lx_reg, rx_reg, den_reg, sat_reg;
    logic [W-1:0]         a_reg, b_reg, qn_reg, qd_reg, prem_reg;
    logic [W-1:0]         ln_mag;

    logic                 accept, out_free, out_load, mul_start, div_start;
    rau_pkg::mul_step_t   mul_last;
    rau_pkg::unit_status_t mul_st, div_st;
    logic signed [AW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_p;
    logic [W-1:0]         div_n, div_d, div_q, div_r;
    logic [PW-NW:0]       p_top;

    logic                 m_tvalid_reg;
    logic signed [IW-1:0] res_int_reg, res_int;
    logic signed [NW-1:0] res_num_reg, res_num, res_den_reg, res_den;
    logic                 flag_reg, flag;
    logic signed [IW-1:0] q_signed;

    assign ln_mag   = ln_reg[W-1] ? W'(-ln_reg) : W'(ln_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // The product that ends the multiply sequence for this opcode.
    always_comb begin
        if (op_reg == rau_pkg::OP_MUL) begin
            mul_last = rau_pkg::MS_PROD;
        end else if (op_reg <= rau_pkg::OP_DIV) begin
            mul_last = rau_pkg::MS_DEN;
        end else begin
            mul_last = rau_pkg::MS_RIGHT_X;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rau_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (in_op <= rau_pkg::OP_LE) begin
                        state_next = rau_pkg::ST_MUL_GO;
                    end else if (in_op == rau_pkg::OP_REDUCE) begin
                        state_next = (in_ln == '0) ? rau_pkg::ST_FINISH : rau_pkg::ST_DIV_GO;
                    end else if (in_op == rau_pkg::OP_PROPER) begin
                        state_next = rau_pkg::ST_DIV_GO;
                    end else begin
                        state_next = rau_pkg::ST_FINISH;
                    end
                end
            end
            rau_pkg::ST_MUL_GO: begin
                if (!mul_st.busy) state_next = rau_pkg::ST_MUL_WAIT;
            end
            rau_pkg::ST_MUL_WAIT: begin
                if (mul_st.done) begin
                    state_next = (mul_step_reg == mul_last) ? rau_pkg::ST_FINISH
                                                            : rau_pkg::ST_MUL_GO;
                end
            end
            rau_pkg::ST_DIV_GO: begin
                if (!div_st.busy) state_next = rau_pkg::ST_DIV_WAIT;
            end
            rau_pkg::ST_DIV_WAIT: begin
                if (div_st.done) begin
                    if (div_phase_reg == rau_pkg::DP_DEN ||
                        div_phase_reg == rau_pkg::DP_PROPER) begin
                        state_next = rau_pkg::ST_FINISH;
                    end else begin
                        state_next = rau_pkg::ST_DIV_GO;
                    end
                end
            end
            rau_pkg::ST_FINISH: begin
                if (out_free) state_next = rau_pkg::ST_IDLE;
            end
            default: state_next = rau_pkg::ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        s_tready  = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            rau_pkg::ST_IDLE:   s_tready  = 1'b1;
            rau_pkg::ST_MUL_GO: mul_start = !mul_st.busy;
            rau_pkg::ST_DIV_GO: div_start = !div_st.busy;
            rau_pkg::ST_FINISH: out_load  = out_free;
            default: ;
        endcase
    end

    // Multiplier operands for each product of the sequence.
    always_comb begin
        case (mul_step_reg)
            rau_pkg::MS_LEFT_N: begin
                mul_a = AW'(li_reg);
                mul_b = $signed(AW'(ld_reg));
            end
            rau_pkg::MS_RIGHT_N: begin
                mul_a = AW'(ri_reg);
                mul_b = $signed(AW'(rd_reg));
            end
            rau_pkg::MS_LEFT_X: begin
                mul_a = left_num_reg;
                mul_b = $signed(AW'(rd_reg));
            end
            rau_pkg::MS_RIGHT_X: begin
                mul_a = right_num_reg;
                mul_b = $signed(AW'(ld_reg));
            end
            rau_pkg::MS_DEN: begin
                mul_a = $signed(AW'(ld_reg));
                mul_b = (op_reg == rau_pkg::OP_DIV) ? right_num_reg : $signed(AW'(rd_reg));
            end
            default: begin
                mul_a = left_num_reg;
                mul_b = right_num_reg;
            end
        endcase
    end

    // Divider operands: Euclid steps, the two reductions, or the proper-form split.
    always_comb begin
        case (div_phase_reg)
            rau_pkg::DP_GCD: begin
                div_n = a_reg;
                div_d = b_reg;
            end
            rau_pkg::DP_NUM: begin
                div_n = ln_mag;
                div_d = b_reg;
            end
            rau_pkg::DP_DEN: begin
                div_n = W'(ld_reg);
                div_d = b_reg;
            end
            default: begin
                div_n = ln_mag;
                div_d = W'(ld_reg);
            end
        endcase
    end

    rau_mul #(.AW(AW)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .status  (mul_st),
        .product (mul_p)
    );

    rau_div #(.NB(W)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_n),
        .divisor   (div_d),
        .status    (div_st),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // The full product overflows the numerator field unless its top bits agree.
    assign p_top = mul_p[PW-1:NW-1];

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rau_pkg::ST_IDLE;
            m_tvalid_reg  <= 1'b0;
            mul_step_reg  <= rau_pkg::MS_LEFT_N;
            div_phase_reg <= rau_pkg::DP_GCD;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (accept) begin
                mul_step_reg  <= rau_pkg::MS_LEFT_N;
                div_phase_reg <= (in_op == rau_pkg::OP_PROPER) ? rau_pkg::DP_PROPER
                                                                : rau_pkg::DP_GCD;
            end
            if (state_reg == rau_pkg::ST_MUL_WAIT && mul_st.done) begin
                mul_step_reg <= rau_pkg::mul_step_t'(3'(mul_step_reg + 3'd1));
            end
            if (state_reg == rau_pkg::ST_DIV_WAIT && div_st.done) begin
                case (div_phase_reg)
                    rau_pkg::DP_GCD: if (div_r == '0) div_phase_reg <= rau_pkg::DP_NUM;
                    rau_pkg::DP_NUM: div_phase_reg <= rau_pkg::DP_DEN;
                    default: ;
                endcase
            end
        end
    end

    // Operand capture and intermediate results.
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg <= in_op;
            li_reg <= in_li;
            ln_reg <= in_ln;
            ri_reg <= in_ri;
            rn_reg <= in_rn;
            ld_reg <= (in_ld_raw == '0) ? DW'(1) : in_ld_raw;
            rd_reg <= (in_rd_raw == '0) ? DW'(1) : in_rd_raw;
            a_reg  <= in_ln_mag;
            b_reg  <= (in_ld_raw == '0) ? W'(1) : W'(in_ld_raw);
        end
        if (state_reg == rau_pkg::ST_MUL_WAIT && mul_st.done) begin
            case (mul_step_reg)
                rau_pkg::MS_LEFT_N:  left_num_reg  <= mul_p[AW-1:0] + AW'(ln_reg);
                rau_pkg::MS_RIGHT_N: right_num_reg <= mul_p[AW-1:0] + AW'(rn_reg);
                rau_pkg::MS_LEFT_X:  lx_reg  <= mul_p[NW-1:0];
                rau_pkg::MS_RIGHT_X: rx_reg  <= mul_p[NW-1:0];
                rau_pkg::MS_DEN:     den_reg <= mul_p[NW-1:0];
                default: begin
                    if (p_top == '0 || p_top == '1) begin
                        sat_reg <= mul_p[NW-1:0];
                    end else begin
                        sat_reg <= {mul_p[PW-1], {(NW-1){~mul_p[PW-1]}}};
                    end
                end
            endcase
        end
        if (state_reg == rau_pkg::ST_DIV_WAIT && div_st.done) begin
            case (div_phase_reg)
                rau_pkg::DP_GCD: begin
                    if (div_r != '0) begin
                        a_reg <= b_reg;
                        b_reg <= div_r;
                    end
                end
                rau_pkg::DP_NUM: qn_reg <= div_q;
                rau_pkg::DP_DEN: qd_reg <= div_q;
                default: begin
                    qn_reg   <= div_q;
                    prem_reg <= div_r;
                end
            endcase
        end
    end

    // Truncating quotient with the sign of the numerator.
    assign q_signed = ln_reg[W-1] ? -$signed(IW'(qn_reg)) : $signed(IW'(qn_reg));

    // Result assembly.
    always_comb begin
        res_int = '0;
        res_num = '0;
        res_den = '0;
        flag    = 1'b0;
        case (op_reg)
            rau_pkg::OP_ADD: begin
                res_num = lx_reg + rx_reg;
                res_den = den_reg;
            end
            rau_pkg::OP_SUB: begin
                res_num = lx_reg - rx_reg;
                res_den = den_reg;
            end
            rau_pkg::OP_MUL: begin
                res_num = sat_reg;
                res_den = den_reg;
            end
            rau_pkg::OP_DIV: begin
                res_num = lx_reg;
                res_den = (den_reg == '0) ? NW'(1) : den_reg;
            end
            rau_pkg::OP_EQ: flag = (lx_reg == rx_reg);
            rau_pkg::OP_NE: flag = (lx_reg != rx_reg);
            rau_pkg::OP_GT: flag = (lx_reg > rx_reg);
            rau_pkg::OP_LT: flag = (lx_reg < rx_reg);
            rau_pkg::OP_GE: flag = !(lx_reg < rx_reg);
            rau_pkg::OP_LE: flag = !(lx_reg > rx_reg);
            rau_pkg::OP_REDUCE: begin
                res_int = IW'(li_reg);
                if (ln_reg == '0) begin
                    res_num = '0;
                    res_den = $signed(NW'(ld_reg));
                end else begin
                    res_num = ln_reg[W-1] ? -$signed(NW'(qn_reg)) : $signed(NW'(qn_reg));
                    res_den = $signed(NW'(qd_reg));
                end
            end
            rau_pkg::OP_PROPER: begin
                res_int = IW'(li_reg) + q_signed;
                res_num = ln_reg[W-1] ? -$signed(NW'(prem_reg)) : $signed(NW'(prem_reg));
                res_den = $signed(NW'(ld_reg));
            end
            default: ;
        endcase
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            res_int_reg <= res_int;
            res_num_reg <= res_num;
            res_den_reg <= res_den;
            flag_reg    <= flag;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_PAD'({flag_reg, res_den_reg, res_num_reg, res_int_reg});

endmodule

// ===== hdl/rau_checker.sv =====
`include "rational_arithmetic_unit_macros.svh"

module rau_checker #(
    parameter int OPERAND_BITS = 16
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [(((6 * OPERAND_BITS - 2) + 7) / 8) * 8 - 1:0] s_tdata,
    input logic [3:0]          s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [((7 * OPERAND_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int W      = OPERAND_BITS;
    localparam int FLAG_I = 7 * W - 1;

    // A stalled result must hold its value.
    `RAU_ASSERT_CLK(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // Reset leaves no result pending.
    `RAU_ASSERT_RST(a_reset_clear, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // A request occupies the sequencer, so s_tready drops after each accept.
    `RAU_ASSERT_CLK(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "request accepted back to back")

    // A true compare flag comes with an empty fraction.
    `RAU_ASSERT_CLK(a_flag_only, aclk, aresetn, m_tvalid && m_tdata[FLAG_I] |-> m_tdata[FLAG_I-1:W+1] == '0, "flag set with nonzero fraction")

endmodule

bind rational_arithmetic_unit rau_checker #(.OPERAND_BITS(OPERAND_BITS)) u_rau_checker (.*);
